### src/miller_rabin_primality_test_assert.svh
// Assertion macros for the Miller-Rabin primality tester.
// No dependencies; included by the top level only.
`ifndef MILLER_RABIN_PRIMALITY_TEST_ASSERT_SVH
`define MILLER_RABIN_PRIMALITY_TEST_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define MR_ASSERT_IMPL(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define MR_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/mrpt_pkg.sv
// Shared types and constants for the Miller-Rabin primality tester.
// No dependencies.
package mrpt_pkg;
	localparam int BaseTableSize = 12;
	localparam int BaseWidth = 6;

	// Commands from the controller to the datapath.
	typedef enum logic [3:0] {
		CMD_NONE    = 4'd0,
		CMD_LOAD    = 4'd1,  // latch candidate, start splitting off twos
		CMD_SHIFT   = 4'd2,  // one step of removing a factor of two from d
		CMD_INITB   = 4'd3,  // g = base (reduced by CMD_REDB), acc = 1 (0 if n is 1), bit pointer = top
		CMD_SQ      = 4'd4,  // start acc = acc*acc mod n
		CMD_MULB    = 4'd5,  // start acc = acc*g mod n
		CMD_NEXTBIT = 4'd6,  // move bit pointer down
		CMD_SQX     = 4'd7,  // start x = x*x mod n (squaring phase)
		CMD_ACC2X   = 4'd8,  // x = acc, k = 1
		CMD_INCK    = 4'd9,
		CMD_REDB    = 4'd10  // one reduction step of the base
	} cmd_t;

	typedef struct packed {
		logic n_small;     // candidate below two
		logic d_even;      // d still even and nonzero
		logic mul_busy;
		logic ebit;        // current exponent bit of d
		logic bit_last;    // bit pointer at zero
		logic base_red;    // base already below n
		logic n_is_base;
		logic x_one;
		logic x_nm1;
		logic k_done;      // k >= s
	} status_t;

	function automatic logic [BaseWidth-1:0] base_at(input logic [3:0] idx);
		logic [BaseWidth-1:0] b;
		begin
			case (idx)
				4'd0: b = 6'd2;
				4'd1: b = 6'd3;
				4'd2: b = 6'd5;
				4'd3: b = 6'd7;
				4'd4: b = 6'd11;
				4'd5: b = 6'd13;
				4'd6: b = 6'd17;
				4'd7: b = 6'd19;
				4'd8: b = 6'd23;
				4'd9: b = 6'd29;
				4'd10: b = 6'd31;
				4'd11: b = 6'd37;
				default: b = 6'd2;
			endcase
			return b;
		end
	endfunction
endpackage

### src/mrpt_modmul.sv
// Bit-serial modular multiplier: one doubling and one conditional add per cycle.
// Depends on nothing but its ports.
module mrpt_modmul #(
	parameter int W = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         busy,
	output logic [W-1:0] prod
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] acc_q, a_q, b_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [W:0] dbl, dred, sum;
	logic [W-1:0] step;

	always_comb begin
		dbl = {acc_q, 1'b0};
		dred = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum = dred + {1'b0, a_q};
		if (b_q[W-1])
			step = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
		else
			step = dred[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			acc_q <= step;
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;
endmodule

### src/mrpt_datapath.sv
// Datapath of the primality tester: candidate, odd part, power and square registers.
// Depends on mrpt_pkg and mrpt_modmul.
module mrpt_datapath #(
	parameter int W = 63
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mrpt_pkg::cmd_t      cmd,
	input  logic [3:0]          base_idx,
	input  logic [W-1:0]        cand,
	output mrpt_pkg::status_t   status
);
	import mrpt_pkg::*;
	localparam int PW = $clog2(W);
	localparam int SW = $clog2(W + 1);

	logic [W-1:0] n_q, d_q, acc_q, x_q, g_q;
	logic [SW-1:0] s_q, k_q;
	logic [PW-1:0] bp_q;
	logic mstart, mbusy, msel_q;
	logic [W-1:0] ma, mb, mprod;
	logic [W-1:0] nm1;
	logic [W-1:0] base_w;

	assign nm1 = n_q - 1'b1;
	assign base_w = W'(base_at(base_idx));
	assign mstart = (cmd == CMD_SQ) || (cmd == CMD_MULB) || (cmd == CMD_SQX);

	always_comb begin
		case (cmd)
			CMD_SQ: begin ma = acc_q; mb = acc_q; end
			CMD_MULB: begin ma = g_q; mb = acc_q; end
			default: begin ma = x_q; mb = x_q; end
		endcase
	end

	mrpt_modmul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb), .m(n_q),
		.busy(mbusy), .prod(mprod)
	);

	// Result of the multiplier lands once it goes idle after a start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) msel_q <= 1'b0;
		else if (mstart) msel_q <= 1'b1;
		else if (!mbusy && msel_q) msel_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				n_q <= cand;
				d_q <= cand - 1'b1;
				s_q <= '0;
			end
			CMD_SHIFT: begin
				d_q <= d_q >> 1;
				s_q <= s_q + 1'b1;
			end
			CMD_INITB: begin
				g_q <= base_w;
				acc_q <= (n_q == W'(1)) ? '0 : W'(1);
				bp_q <= PW'(W - 1);
			end
			CMD_REDB: g_q <= g_q - n_q;
			CMD_NEXTBIT: bp_q <= bp_q - 1'b1;
			CMD_ACC2X: begin
				x_q <= acc_q;
				k_q <= SW'(1);
			end
			CMD_INCK: k_q <= k_q + 1'b1;
			default: ;
		endcase
		if (!mbusy && msel_q && !mstart) begin
			acc_q <= mprod;
			x_q <= mprod;
		end
	end

	assign status.n_small = (n_q < W'(2));
	assign status.d_even = (d_q != '0) && !d_q[0];
	assign status.mul_busy = mbusy || mstart || msel_q;
	assign status.ebit = d_q[bp_q];
	assign status.bit_last = (bp_q == '0);
	assign status.base_red = (g_q < n_q);
	assign status.n_is_base = (n_q == base_w);
	assign status.x_one = (x_q == W'(1));
	assign status.x_nm1 = (x_q == nm1);
	assign status.k_done = (k_q >= s_q);
endmodule

### src/mrpt_ctrl.sv
// Controller state machine of the primality tester.
// Depends on mrpt_pkg.
module mrpt_ctrl #(
	parameter int NUM_BASES = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_fire,
	input  mrpt_pkg::status_t status,
	output mrpt_pkg::cmd_t    cmd,
	output logic [3:0]        base_idx,
	output logic              idle,
	output logic              done,
	output logic              verdict
);
	import mrpt_pkg::*;
	localparam int Count = (NUM_BASES > BaseTableSize) ? BaseTableSize : NUM_BASES;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SPLIT = 11'b00000000010,
		S_BASE  = 11'b00000000100,
		S_RED   = 11'b00000001000,
		S_SQ    = 11'b00000010000,
		S_MUL   = 11'b00000100000,
		S_BIT   = 11'b00001000000,
		S_CHK   = 11'b00010000000,
		S_SQX   = 11'b00100000000,
		S_CHKX  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [3:0] idx_q;
	logic verdict_q, wait_q;

	assign base_idx = idx_q;
	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);
	assign verdict = verdict_q;

	always_comb begin
		cmd = CMD_NONE;
		case (state_q)
			S_IDLE: if (in_fire) cmd = CMD_LOAD;
			S_SPLIT: if (status.d_even) cmd = CMD_SHIFT;
				else if (!status.n_small) cmd = CMD_INITB;
			S_BASE: if (!status.base_red) cmd = CMD_REDB;
			S_RED: if (!status.base_red) cmd = CMD_REDB;
			S_SQ: if (!wait_q) cmd = CMD_SQ;
			S_MUL: if (!wait_q) cmd = CMD_MULB;
			S_BIT: if (!status.bit_last) cmd = CMD_NEXTBIT;
				else cmd = CMD_ACC2X;
			S_SQX: if (!wait_q) cmd = CMD_SQX;
			S_CHKX: if (!status.x_one && !status.x_nm1) cmd = CMD_INCK;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			verdict_q <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_SPLIT;
					idx_q <= '0;
				end
				S_SPLIT: if (!status.d_even) begin
					if (status.n_small) begin
						verdict_q <= 1'b0;
						state_q <= S_DONE;
					end else state_q <= S_RED;
				end
				S_RED: if (status.base_red) begin
					if (status.n_is_base) begin
						state_q <= S_BASE;
					end else begin
						state_q <= S_SQ;
						wait_q <= 1'b0;
					end
				end
				// The base passed (it equals n, or x reached 1 or n-1); move to the next one.
				S_BASE: begin
					if (idx_q == 4'(Count - 1)) begin
						verdict_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SPLIT;
					end
				end
				S_SQ: if (!wait_q) wait_q <= 1'b1;
					else if (!status.mul_busy) begin
						wait_q <= 1'b0;
						state_q <= status.ebit ? S_MUL : S_BIT;
					end
				S_MUL: if (!wait_q) wait_q <= 1'b1;
					else if (!status.mul_busy) begin
						wait_q <= 1'b0;
						state_q <= S_BIT;
					end
				S_BIT: state_q <= status.bit_last ? S_CHK : S_SQ;
				S_CHK: if (status.x_one || status.x_nm1) state_q <= S_BASE;
					else if (status.k_done) begin
						verdict_q <= 1'b0;
						state_q <= S_DONE;
					end else state_q <= S_SQX;
				S_SQX: if (!wait_q) wait_q <= 1'b1;
					else if (!status.mul_busy) begin
						wait_q <= 1'b0;
						state_q <= S_CHKX;
					end
				S_CHKX: if (status.x_one) begin
						verdict_q <= 1'b0;
						state_q <= S_DONE;
					end else if (status.x_nm1) state_q <= S_BASE;
					else state_q <= S_CHK;
				S_DONE: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/miller_rabin_primality_test.sv
// Miller-Rabin primality tester over the fixed prime bases 2, 3, 5, ... (NUM_BASES of them, at most 12).
// Modular products are computed one at a time, and only one candidate is tested at a time:
// the next candidate is taken in the cycle after the result transfer.
// Reset (arst_n low) is asynchronous and returns the controller to idle.
module miller_rabin_primality_test #(
	parameter int NUM_BASES = 9,
	parameter int VALUE_BITS = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [VALUE_BITS-1:0] candidate
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] is_prime
);
	import mrpt_pkg::*;
	`include "miller_rabin_primality_test_assert.svh"

	cmd_t cmd;
	status_t status;
	logic [3:0] base_idx;
	logic idle, done, verdict, in_fire, out_fire;

	assign s_axis_tready = idle;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = done;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {7'd0, verdict};

	mrpt_ctrl #(.NUM_BASES(NUM_BASES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.status(status), .cmd(cmd), .base_idx(base_idx), .idle(idle), .done(done),
		.verdict(verdict)
	);

	mrpt_datapath #(.W(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .base_idx(base_idx),
		.cand(s_axis_tdata[VALUE_BITS-1:0]), .status(status)
	);

	`MR_ASSERT_IMPL(a_excl, clk, arst_n, 1'b1, !(s_axis_tready && m_axis_tvalid))
	`MR_ASSERT_NEXT(a_take, clk, arst_n, in_fire, !s_axis_tready)
	`MR_ASSERT_NEXT(a_back, clk, arst_n, out_fire, s_axis_tready)
endmodule
